[hw/rtl/b64e_pkg.sv]
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the sextet-to-character mapping of the Base64
// stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] CFG_URL_ALPHABET = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PAD_CHAR     = 1'd1;

	localparam logic [7:0] PAD_CHAR_RESET = 8'd61;

	typedef struct packed {
		logic [5:0] s0;
		logic [5:0] s1;
		logic       two;
		logic [1:0] npad;
		logic       fin;
	} b64e_job_t;

	function automatic logic [7:0] sextet_to_char(input logic [5:0] v, input logic url);
		logic [7:0] c;
		begin
			if (v < 6'd26) begin
				c = 8'h41 + {2'b00, v};
			end else if (v < 6'd52) begin
				c = 8'h61 + {2'b00, v - 6'd26};
			end else if (v < 6'd62) begin
				c = 8'h30 + {2'b00, v - 6'd52};
			end else if (v == 6'd62) begin
				c = url ? 8'h2D : 8'h2B;
			end else begin
				c = url ? 8'h5F : 8'h2F;
			end
			return c;
		end
	endfunction

endpackage

[hw/rtl/b64e_byte_if.sv]
// ----------------------------------------------------------------------------
// b64e_byte_if
// Raw byte channel with last-byte flag.
// ----------------------------------------------------------------------------
interface b64e_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

[hw/rtl/b64e_char_if.sv]
// ----------------------------------------------------------------------------
// b64e_char_if
// Encoded character channel with end-of-message flag.
// ----------------------------------------------------------------------------
interface b64e_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       end_of_message;

	modport source (output valid, output out_char, output end_of_message, input ready);
	modport sink   (input valid, input out_char, input end_of_message, output ready);
endinterface

[hw/rtl/base64_stream_encoder_top.sv]
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Base64 encoder: raw bytes in, standard or URL-safe characters out.
// ----------------------------------------------------------------------------
// Each accepted byte yields one character (first or second byte of a group)
// or two (third byte); a final byte flushes the partial group and adds up to
// two pad characters when pad_char is nonzero, with end_of_message on the
// last one. The output register emits one character per cycle while the
// sink is ready; the first character of a byte passes through the job queue
// and then the output register. The job queue of QUEUE_DEPTH entries lets
// byte intake run ahead of a stalled output.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top
	import b64e_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	b64e_byte_if.sink              bytes,
	b64e_char_if.source            chars,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	logic       url_q;
	logic [7:0] pad_q;
	logic       q_push;
	logic       q_full;
	b64e_job_t  new_job;
	b64e_job_t  head_job;
	logic       empty;
	logic       pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			url_q <= 1'b0;
			pad_q <= PAD_CHAR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_URL_ALPHABET: url_q <= cfg_wdata[0];
				CFG_PAD_CHAR:     pad_q <= cfg_wdata[7:0];
				default:          url_q <= url_q;
			endcase
		end
	end

	b64e_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.push   (q_push),
		.full   (q_full),
		.job    (new_job)
	);

	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (new_job),
		.full     (q_full),
		.pop      (pop),
		.head_job (head_job),
		.empty    (empty)
	);

	b64e_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.url_alphabet (url_q),
		.pad_char     (pad_q),
		.head_job     (head_job),
		.empty        (empty),
		.pop          (pop),
		.chars        (chars)
	);

endmodule

[hw/rtl/b64e_front.sv]
// ----------------------------------------------------------------------------
// b64e_front
// Accepts bytes, tracks the position in the 3-byte group and the leftover
// bits, and turns each byte into one character job.
// ----------------------------------------------------------------------------
module b64e_front
	import b64e_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	b64e_byte_if.sink         bytes,
	output logic              push,
	input  logic              full,
	output b64e_job_t         job
);

	logic [1:0] pos_q;
	logic [3:0] left_q;
	logic [1:0] pos_d;
	logic [3:0] left_d;
	logic       take;
	logic [7:0] b;
	logic       fin;

	assign bytes.ready = !full;
	assign take        = bytes.valid && !full;
	assign push        = take;
	assign b           = bytes.data_byte;
	assign fin         = bytes.final_byte;

	always_comb begin
		job.fin = fin;
		case (pos_q)
			2'd1: begin
				job.s0   = {left_q[1:0], b[7:4]};
				job.s1   = {b[3:0], 2'b00};
				job.two  = fin;
				job.npad = fin ? 2'd1 : 2'd0;
				pos_d    = 2'd2;
				left_d   = b[3:0];
			end
			2'd2: begin
				job.s0   = {left_q, b[7:6]};
				job.s1   = b[5:0];
				job.two  = 1'b1;
				job.npad = 2'd0;
				pos_d    = 2'd0;
				left_d   = 4'd0;
			end
			default: begin
				job.s0   = b[7:2];
				job.s1   = {b[1:0], 4'b0000};
				job.two  = fin;
				job.npad = fin ? 2'd2 : 2'd0;
				pos_d    = 2'd1;
				left_d   = {2'b00, b[1:0]};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 2'd0;
			left_q <= 4'd0;
		end else if (take) begin
			pos_q  <= fin ? 2'd0 : pos_d;
			left_q <= fin ? 4'd0 : left_d;
		end
	end

endmodule

[hw/rtl/b64e_queue.sv]
// ----------------------------------------------------------------------------
// b64e_queue
// Short FIFO of character jobs between the front and back parts.
// ----------------------------------------------------------------------------
module b64e_queue
	import b64e_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  b64e_job_t push_job,
	output logic      full,
	input  logic      pop,
	output b64e_job_t head_job,
	output logic      empty
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	b64e_job_t         mem_q [DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [CW-1:0]     cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hw/rtl/b64e_back.sv]
// ----------------------------------------------------------------------------
// b64e_back
// Walks the head job one character per cycle unless stalled, maps sextets
// via the selected alphabet, appends padding and drives the output register.
// ----------------------------------------------------------------------------
module b64e_back
	import b64e_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        url_alphabet,
	input  logic [7:0]  pad_char,
	input  b64e_job_t   head_job,
	input  logic        empty,
	output logic        pop,
	b64e_char_if.source chars
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] char_q;
	logic       eom_q;
	logic       load;
	logic       last;
	logic [2:0] total;
	logic [7:0] ch;

	assign load  = !empty && (!valid_q || chars.ready);
	assign total = (head_job.two ? 3'd2 : 3'd1)
		+ ((pad_char != 8'd0) ? {1'b0, head_job.npad} : 3'd0);
	assign last  = ({1'b0, idx_q} + 3'd1) == total;
	assign pop   = load && last;

	always_comb begin
		if (idx_q == 2'd0) begin
			ch = sextet_to_char(head_job.s0, url_alphabet);
		end else if (idx_q == 2'd1 && head_job.two) begin
			ch = sextet_to_char(head_job.s1, url_alphabet);
		end else begin
			ch = pad_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last ? 2'd0 : idx_q + 2'd1;
			end else if (chars.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= ch;
			eom_q  <= last && head_job.fin;
		end
	end

	assign chars.valid          = valid_q;
	assign chars.out_char       = char_q;
	assign chars.end_of_message = eom_q;

endmodule
